// File: rtl/pba_pkg.sv
// Package for the page bitmap allocator: sizes, opcodes and beat structs.
// No dependencies.
`default_nettype none
package pba_pkg;
  localparam int MaxPages  = 4096;
  localparam int WordBits  = 64;
  localparam int MapWords  = MaxPages / WordBits;
  localparam int WAW       = $clog2(MapWords);
  localparam int BW        = $clog2(WordBits);
  localparam int RegW      = 13;
  localparam int PageW     = 12;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RESERVE = 2'd2;
  localparam logic [1:0] OP_FREERNG = 2'd3;

  localparam logic [1:0] CFG_TOTAL = 2'd0;
  localparam logic [1:0] CFG_RLOW  = 2'd1;
  localparam logic [1:0] CFG_PFST  = 2'd2;
  localparam logic [1:0] CFG_PEND  = 2'd3;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [PageW-1:0] start_page;
    logic [RegW-1:0] page_count;
  } req_t;

  typedef struct packed {
    logic            status;
    logic [PageW-1:0] result_page;
    logic [RegW-1:0] free_pages;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch request
    logic rd;       // issue memory read at page pointer
    logic scan;     // alloc: evaluate page (data valid)
    logic apply;    // range: evaluate/write page
    logic rewind;   // alloc: set pointer to run start for marking
    logic mark;     // alloc: mark page used
    logic clr;      // reset clearing pass write
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_alloc;
    logic zero_cnt;
    logic found;
    logic ptr_done;   // pointer at/after end bound, or run found
    logic mark_done;  // marking reached last page of run
    logic clr_done;
  } sts_t;
endpackage
`default_nettype wire

// File: rtl/page_bitmap_allocator.sv
// Page bitmap allocator, top level: controller plus datapath.
// Depends on pba_pkg, pba_ctrl, pba_datapath.
// Usage: raise start with req_i while busy is low; the request is taken at
// that edge. One result beat follows, shown for exactly one cycle with
// rsp_valid_o high; the receiver cannot stall it.
// Steps: allocate reads and scans each page up to the end of the first
// fitting run, then rewinds to the run start and reads and marks each
// page of that run; a zero-count allocate walks no page; a failed
// allocate and range operations read and evaluate each page walked. The
// single-port bitmap memory takes one read and one write per page.
// After reset a clearing pass sets all 64 bitmap words to all-used;
// busy stays high meanwhile. Configuration writes (cfg_we_i, cfg_idx_i,
// cfg_data_i) are taken at any edge and should be made while idle.
`default_nettype none
module page_bitmap_allocator import pba_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  req_t                 req_i,
  output logic                 rsp_valid_o,
  output rsp_t                 rsp_o,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [RegW-1:0] cfg_data_i
);
  cmd_t cmd;
  sts_t sts;

  pba_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .done_o(rsp_valid_o), .cmd_o(cmd), .sts_i(sts)
  );

  pba_datapath u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .rsp_o
  );
endmodule
`default_nettype wire

// File: rtl/pba_ctrl.sv
// Controller state machine for the page bitmap allocator.
// Depends on pba_pkg.
`default_nettype none
module pba_ctrl import pba_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  output logic      done_o,
  output cmd_t      cmd_o,
  input  sts_t      sts_i
);
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_MRD  = 3'd4;
  localparam logic [2:0] S_MWR  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLR;
    else state_q <= state_d;
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    done_o  = 1'b0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (sts_i.ptr_done || (sts_i.is_alloc && sts_i.zero_cnt)) state_d = S_DONE;
        else begin
          cmd_o.rd = 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.is_alloc) cmd_o.scan = 1'b1;
        else cmd_o.apply = 1'b1;
        state_d = S_RD;
        if (sts_i.is_alloc && sts_i.found) begin
          cmd_o.rewind = 1'b1;
          state_d = S_MRD;
        end
      end
      S_MRD: begin
        cmd_o.rd = 1'b1;
        state_d = S_MWR;
      end
      S_MWR: begin
        cmd_o.mark = 1'b1;
        state_d = sts_i.mark_done ? S_DONE : S_MRD;
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/pba_datapath.sv
// Datapath: bitmap memory, page pointer, run tracking and free counter.
// Depends on pba_pkg.
`default_nettype none
module pba_datapath import pba_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  req_t                 req_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [RegW-1:0] cfg_data_i,
  output rsp_t                 rsp_o
);
  logic [WordBits-1:0] mem_q [MapWords];
  logic [WordBits-1:0] rdata_q;

  logic [RegW-1:0] total_q, rlow_q, pfst_q, pend_q;
  logic [RegW-1:0] ptr_q, end_q, run_q, first_q, cnt_q, free_q, last_q;
  logic [1:0]      op_q;
  logic            found_q, status_q;
  logic [WAW:0]    clr_q;
  logic [RegW-1:0] lim;

  assign lim = (total_q > RegW'(MaxPages)) ? RegW'(MaxPages) : total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= RegW'(4096);
      rlow_q  <= RegW'(256);
      pfst_q  <= '0;
      pend_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOTAL: total_q <= cfg_data_i;
        CFG_RLOW:  rlow_q  <= cfg_data_i;
        CFG_PFST:  pfst_q  <= cfg_data_i;
        CFG_PEND:  pend_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [WAW-1:0] waddr;
  logic [BW-1:0]  bsel;
  logic           bit_used, win, do_set, do_clr;
  assign waddr    = ptr_q[BW +: WAW];
  assign bsel     = ptr_q[BW-1:0];
  assign bit_used = rdata_q[bsel];
  assign win      = (pend_q > pfst_q) && (ptr_q >= pfst_q) && (ptr_q < pend_q);
  assign do_clr   = cmd_i.apply && bit_used &&
                    ((op_q == OP_FREE) || ((op_q == OP_FREERNG) && !win));
  assign do_set   = (cmd_i.apply && !bit_used && (op_q == OP_RESERVE)) ||
                    (cmd_i.mark && !bit_used);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr && !clr_q[WAW]) mem_q[clr_q[WAW-1:0]] <= '1;
    else if (do_clr || do_set) begin
      mem_q[waddr] <= do_set ? (rdata_q | (WordBits'(1) << bsel))
                             : (rdata_q & ~(WordBits'(1) << bsel));
    end
    if (cmd_i.rd) rdata_q <= mem_q[waddr];
  end

  logic [RegW:0] endsum;
  logic [RegW-1:0] firstp;
  assign endsum = {2'b0, req_i.start_page} + {1'b0, req_i.page_count};
  assign firstp = ({1'b0, req_i.start_page} < rlow_q) ? rlow_q : {1'b0, req_i.start_page};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0; free_q <= '0; ptr_q <= '0; end_q <= '0; run_q <= '0;
      first_q <= '0; cnt_q <= '0; last_q <= '0; op_q <= OP_ALLOC;
      found_q <= 1'b0; status_q <= 1'b0;
    end else begin
      if (cmd_i.clr && !clr_q[WAW]) clr_q <= clr_q + 1'b1;
      if (cmd_i.load) begin
        op_q    <= req_i.opcode;
        cnt_q   <= req_i.page_count;
        run_q   <= '0;
        found_q <= 1'b0;
        status_q <= (req_i.opcode == OP_ALLOC);
        case (req_i.opcode)
          OP_ALLOC: begin ptr_q <= '0; end_q <= lim; end
          OP_FREERNG: begin
            ptr_q <= firstp;
            end_q <= (endsum > {1'b0, lim}) ? lim : endsum[RegW-1:0];
          end
          default: begin
            ptr_q <= {1'b0, req_i.start_page};
            end_q <= (endsum > {1'b0, lim}) ? lim : endsum[RegW-1:0];
          end
        endcase
      end
      if (cmd_i.apply) ptr_q <= ptr_q + 1'b1;
      if (cmd_i.scan) begin
        if (bit_used) run_q <= '0;
        else begin
          run_q <= run_q + 1'b1;
          if (run_q + 1'b1 == cnt_q) begin
            found_q <= 1'b1;
            last_q  <= ptr_q;
            first_q <= ptr_q + 1'b1 - cnt_q;
          end
        end
        if (!(cmd_i.rewind)) ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.rewind) begin
        ptr_q <= ptr_q + 1'b1 - cnt_q;
        status_q <= 1'b0;
      end
      if (cmd_i.mark) ptr_q <= ptr_q + 1'b1;
      if (do_clr) free_q <= free_q + 1'b1;
      if (do_set) free_q <= free_q - 1'b1;
    end
  end

  assign sts_o.is_alloc  = (op_q == OP_ALLOC);
  assign sts_o.zero_cnt  = (cnt_q == '0);
  assign sts_o.found     = !bit_used && (run_q + 1'b1 == cnt_q);
  assign sts_o.ptr_done  = (ptr_q >= end_q) || found_q;
  assign sts_o.mark_done = (ptr_q == last_q);
  assign sts_o.clr_done  = clr_q[WAW];

  assign rsp_o.status      = status_q;
  assign rsp_o.result_page = status_q ? '0 : ((op_q == OP_ALLOC) ? first_q[PageW-1:0] : '0);
  assign rsp_o.free_pages  = free_q;
endmodule
`default_nettype wire
